@@ rtl/lgrs_pkg.sv @@
// Shared types, constants and the Life cell rule for the row stencil unit.
package lgrs_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int ROW_W     = 64;
    localparam int CNT_W     = 16;
    localparam int BW_W      = 7;
    localparam int CFG_W     = 16;
    localparam int CIDX_W    = 1;

    localparam logic [CIDX_W-1:0] CFG_BOARD_WIDTH  = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_BOARD_HEIGHT = 1'b1;

    localparam logic [BW_W-1:0] MAX_WIDTH_V = BW_W'(MAX_WIDTH);
    localparam logic [BW_W-1:0] ROW_W_V     = BW_W'(ROW_W);

    // one queued word: rows above, middle, below and the frame position
    typedef struct packed {
        logic [ROW_W-1:0] row_a;
        logic [ROW_W-1:0] row_b;
        logic [ROW_W-1:0] row_c;
        logic [CNT_W-1:0] idx;
        logic             prev;
        logic             last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [ROW_W-1:0] col_mask(input logic [BW_W-1:0] width);
        logic [BW_W-1:0]  eff;
        logic [ROW_W-1:0] m;
        eff = (width > MAX_WIDTH_V) ? MAX_WIDTH_V : width;
        if (eff >= ROW_W_V) begin
            m = '1;
        end else begin
            m = (ROW_W'(1) << eff) - ROW_W'(1);
        end
        return m;
    endfunction

    function automatic logic [ROW_W-1:0] life_row(
        input logic [ROW_W-1:0] up,
        input logic [ROW_W-1:0] mid,
        input logic [ROW_W-1:0] down,
        input logic [ROW_W-1:0] mask
    );
        logic [ROW_W+1:0] u;
        logic [ROW_W+1:0] m;
        logic [ROW_W+1:0] d;
        logic [ROW_W-1:0] res;
        logic [3:0]       n;
        u = {1'b0, up & mask, 1'b0};
        m = {1'b0, mid & mask, 1'b0};
        d = {1'b0, down & mask, 1'b0};
        for (int x = 0; x < ROW_W; x++) begin
            n = 4'(u[x]) + 4'(u[x+1]) + 4'(u[x+2])
              + 4'(d[x]) + 4'(d[x+1]) + 4'(d[x+2])
              + 4'(m[x]) + 4'(m[x+2]);
            res[x] = m[x+1] ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
        end
        return res & mask;
    endfunction

endpackage

@@ rtl/lgrs_front.sv @@
// Front end: accepts rows, tracks frame position and queues stencil words.
module lgrs_front
    import lgrs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [ROW_W-1:0] i_row_bits,
    input  logic [CNT_W-1:0] i_height,
    input  t_q_stat          i_q_stat,
    output logic             o_push,
    output t_job             o_job
);

    logic [ROW_W-1:0] r_above, n_above;
    logic [ROW_W-1:0] r_mid, n_mid;
    logic [CNT_W-1:0] r_rows, n_rows;
    logic [CNT_W-1:0] h_eff;
    logic             accept;
    logic             first;
    logic             last;

    always_comb begin
        o_stall = i_q_stat.full;
        accept  = i_valid && !i_q_stat.full;
        h_eff   = (i_height == '0) ? CNT_W'(1) : i_height;
        first   = (r_rows == '0);
        last    = ({1'b0, r_rows} + (CNT_W+1)'(1)) >= {1'b0, h_eff};

        o_job.row_a = r_above;
        o_job.row_b = r_mid;
        o_job.row_c = i_row_bits;
        o_job.idx   = r_rows;
        o_job.prev  = !first;
        o_job.last  = last;
        o_push      = accept && (!first || last);

        n_above = r_above;
        n_mid   = r_mid;
        n_rows  = r_rows;
        if (accept) begin
            if (last) begin
                n_above = '0;
                n_mid   = '0;
                n_rows  = '0;
            end else begin
                n_above = first ? '0 : r_mid;
                n_mid   = i_row_bits;
                n_rows  = r_rows + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above <= '0;
            r_mid   <= '0;
            r_rows  <= '0;
        end else begin
            r_above <= n_above;
            r_mid   <= n_mid;
            r_rows  <= n_rows;
        end
    end

endmodule

@@ rtl/lgrs_queue.sv @@
// Two-word queue between the front end and the stencil back end.
module lgrs_queue
    import lgrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    t_job       r_mem [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;

    always_comb begin
        o_stat.full  = (r_cnt == 2'd2);
        o_stat.empty = (r_cnt == 2'd0);
        o_head       = r_mem[r_rd];
        n_wr  = r_wr ^ i_push;
        n_rd  = r_rd ^ i_pop;
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full && !i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("queue pop while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wr == r_rd))
        else $error("queue pointers inconsistent with count");
`endif

endmodule

@@ rtl/lgrs_back.sv @@
// Back end: evaluates the B3/S23 stencil per queued word into the output register.
module lgrs_back
    import lgrs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_job             i_head,
    input  t_q_stat          i_q_stat,
    output logic             o_pop,
    input  logic [BW_W-1:0]  i_width,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [ROW_W-1:0] o_next_row_bits,
    output logic [CNT_W-1:0] o_out_row_index,
    output logic             o_frame_last
);

    logic             r_phase, n_phase;
    logic             r_valid, n_valid;
    logic [ROW_W-1:0] r_bits, n_bits;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_last, n_last;
    logic             cur_phase;
    logic             load_ok;
    logic             emit;
    logic [ROW_W-1:0] mask;

    always_comb begin
        mask      = col_mask(i_width);
        cur_phase = r_phase || !i_head.prev;
        load_ok   = !r_valid || !i_stall;
        emit      = !i_q_stat.empty && load_ok;
        o_pop     = emit && (cur_phase || !i_head.last);

        n_phase = r_phase;
        if (emit) begin
            n_phase = !o_pop;
        end

        n_valid = r_valid && i_stall;
        n_bits  = r_bits;
        n_idx   = r_idx;
        n_last  = r_last;
        if (emit) begin
            n_valid = 1'b1;
            if (cur_phase) begin
                n_bits = life_row(i_head.row_b, i_head.row_c, '0, mask);
                n_idx  = i_head.idx;
                n_last = 1'b1;
            end else begin
                n_bits = life_row(i_head.row_a, i_head.row_b, i_head.row_c, mask);
                n_idx  = i_head.idx - CNT_W'(1);
                n_last = 1'b0;
            end
        end

        o_valid         = r_valid;
        o_next_row_bits = r_bits;
        o_out_row_index = r_idx;
        o_frame_last    = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_idx  <= n_idx;
        r_last <= n_last;
    end

`ifndef ASSERT_OFF
    a_phase_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (!i_q_stat.empty && i_head.last))
        else $error("second result pending without a last-row word");
    a_phase_after_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_phase) |-> ($past(emit) && !$past(cur_phase)))
        else $error("second phase entered without a first result");
    a_last_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && cur_phase) |-> o_pop)
        else $error("last-row result did not retire its word");
`endif

endmodule

@@ rtl/life_generation_row_stencil_unit.sv @@
// Life B3/S23 row stencil unit: top level with configuration registers.
//
// Input channel: one board row per word (i_row_bits, bit x = column x),
// top row first, handshaked by i_valid / o_stall. Output channel: one
// next-generation row per word with its row index and a frame-last flag,
// handshaked by o_valid / i_stall.
// Results trail the input by one row: the first row of a frame produces
// nothing unless it is also the last, each later row produces the result
// for the row before it, and the last row of a frame also produces its own
// result with o_frame_last set. The row that completes an output word is
// queued first; the stencil stage then computes it into the output register.
// Throughput is one row per cycle while the queue is not full; a frame's
// last row stays at the queue head until both of its results are made. A two-word
// queue between the row tracker and the stencil stage absorbs that and lets the
// input keep flowing while a result waits in the output register.
// When i_stall is high the output word holds; the queue fills and o_stall
// rises. Reset clears the row history, the row counter and all valid state,
// and sets width and height to 64. The user writes configuration (i_cfg_wr_en,
// i_cfg_index, i_cfg_data) only while idle; the block does not enforce this.
module life_generation_row_stencil_unit
    import lgrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [ROW_W-1:0]  i_row_bits,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ROW_W-1:0]  o_next_row_bits,
    output logic [CNT_W-1:0]  o_out_row_index,
    output logic              o_frame_last
);

    logic [BW_W-1:0]  r_width;
    logic [CNT_W-1:0] r_height;
    logic             push;
    logic             pop;
    t_job             job;
    t_job             head;
    t_q_stat          q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= BW_W'(64);
            r_height <= CNT_W'(64);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BOARD_WIDTH:  r_width  <= i_cfg_data[BW_W-1:0];
                CFG_BOARD_HEIGHT: r_height <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    lgrs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_row_bits (i_row_bits),
        .i_height   (r_height),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_job      (job)
    );

    lgrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    lgrs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_q_stat        (q_stat),
        .o_pop           (pop),
        .i_width         (r_width),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_next_row_bits (o_next_row_bits),
        .o_out_row_index (o_out_row_index),
        .o_frame_last    (o_frame_last)
    );

endmodule
